[hdl/ofp_pkg.sv]
// Shared constants and types for the optical-flow frame parser and filter.
package ofp_pkg;

    localparam int FRAME_LEN_DEF = 14;
    localparam int POS_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int FLOW_W        = 16;

    localparam logic [BYTE_W-1:0] HDR0_BYTE = 8'hFE;
    localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h55;

    localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
    localparam logic [POS_W-1:0] POS_X_LO   = 4'd2;
    localparam logic [POS_W-1:0] POS_X_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_Y_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI   = 4'd5;
    localparam logic [POS_W-1:0] POS_SPAN_LO = 4'd6;
    localparam logic [POS_W-1:0] POS_SPAN_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_STATUS = 4'd10;

    typedef struct packed {
        logic signed [FLOW_W-1:0] raw_x;
        logic signed [FLOW_W-1:0] raw_y;
        logic [FLOW_W-1:0]        span;
        logic [BYTE_W-1:0]        status;
    } t_frame;

endpackage

[hdl/ofp_parser.sv]
// Byte-wise frame deframer that captures the flow, span and status fields.
module ofp_parser #(
    parameter int FRAME_LEN = ofp_pkg::FRAME_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ofp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_frm_valid,
    input  logic                        i_frm_ready,
    output ofp_pkg::t_frame             o_frm
);
    import ofp_pkg::*;

    localparam logic [POS_W-1:0] TAIL_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             n_load;
    logic             in_accept;
    t_frame           r_fields;
    t_frame           r_frm;
    logic             r_frm_valid;

    assign o_in_ready  = !r_frm_valid || i_frm_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

    always_comb begin
        n_pos  = r_pos;
        n_load = 1'b0;
        if (r_pos == POS_HDR0) begin
            n_pos = (i_rx_byte == HDR0_BYTE) ? POS_HDR1 : POS_HDR0;
        end else if (r_pos == POS_HDR1) begin
            n_pos = (i_rx_byte == HDR1_BYTE) ? POS_X_LO : POS_HDR0;
        end else if (r_pos == TAIL_POS) begin
            n_pos  = POS_HDR0;
            n_load = (i_rx_byte == TAIL_BYTE);
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR0;
        end else if (in_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            case (r_pos)
                POS_X_LO:    r_fields.raw_x[7:0]  <= i_rx_byte;
                POS_X_HI:    r_fields.raw_x[15:8] <= i_rx_byte;
                POS_Y_LO:    r_fields.raw_y[7:0]  <= i_rx_byte;
                POS_Y_HI:    r_fields.raw_y[15:8] <= i_rx_byte;
                POS_SPAN_LO: r_fields.span[7:0]   <= i_rx_byte;
                POS_SPAN_HI: r_fields.span[15:8]  <= i_rx_byte;
                POS_STATUS:  r_fields.status      <= i_rx_byte;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (in_accept && n_load) begin
            r_frm_valid <= 1'b1;
        end else if (i_frm_ready) begin
            r_frm_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_load) begin
            r_frm <= r_fields;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= TAIL_POS)
        else $error("Frame position passed the tail position.");

    a_tail_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_pos == TAIL_POS) |=> r_pos == POS_HDR0)
        else $error("Position did not restart after the tail byte.");

    a_load_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_load) |-> (r_pos == TAIL_POS && i_rx_byte == TAIL_BYTE))
        else $error("Frame loaded away from a good tail byte.");
`endif

endmodule

[hdl/ofp_filter.sv]
// First-order low-pass filter on the flow values with the result register.
module ofp_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_frm_valid,
    output logic                               o_frm_ready,
    input  ofp_pkg::t_frame                    i_frm,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_flow_x,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_flow_y,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_change_x,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_change_y,
    output logic [ofp_pkg::FLOW_W-1:0]         o_time_span,
    output logic [ofp_pkg::BYTE_W-1:0]         o_status_byte
);
    import ofp_pkg::*;

    localparam int                SUM_W      = 20;
    localparam int                RECIP_SH   = 23;
    localparam logic [SUM_W-1:0]  RECIP_TEN  = 20'd838861;

    // Computes (2*raw + 8*prev) / 10 rounded toward zero, using a reciprocal
    // multiply on the magnitude which is exact for the whole input range.
    function automatic logic signed [FLOW_W-1:0] f_lowpass(
        input logic signed [FLOW_W-1:0] raw,
        input logic signed [FLOW_W-1:0] prev
    );
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-1:0]        mag;
        logic [2*SUM_W-1:0]      prod;
        logic [FLOW_W-1:0]       quo;
        sum  = (SUM_W'(raw) <<< 1) + (SUM_W'(prev) <<< 3);
        mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        prod = (2*SUM_W)'(mag) * (2*SUM_W)'(RECIP_TEN);
        quo  = prod[RECIP_SH+FLOW_W-1:RECIP_SH];
        return sum[SUM_W-1] ? FLOW_W'(-quo) : FLOW_W'(quo);
    endfunction

    logic                     frm_take;
    logic signed [FLOW_W-1:0] n_fx;
    logic signed [FLOW_W-1:0] n_fy;
    logic signed [FLOW_W-1:0] r_prev_x;
    logic signed [FLOW_W-1:0] r_prev_y;
    logic                     r_out_valid;
    logic signed [FLOW_W-1:0] r_flow_x;
    logic signed [FLOW_W-1:0] r_flow_y;
    logic signed [FLOW_W-1:0] r_change_x;
    logic signed [FLOW_W-1:0] r_change_y;
    logic [FLOW_W-1:0]        r_span;
    logic [BYTE_W-1:0]        r_status;

    assign o_frm_ready = !r_out_valid || i_out_ready;
    assign frm_take    = i_frm_valid && o_frm_ready;
    assign n_fx        = f_lowpass(i_frm.raw_x, r_prev_x);
    assign n_fy        = f_lowpass(i_frm.raw_y, r_prev_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else if (frm_take) begin
            r_out_valid <= 1'b1;
            r_prev_x    <= n_fx;
            r_prev_y    <= n_fy;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frm_take) begin
            r_flow_x   <= n_fx;
            r_flow_y   <= n_fy;
            r_change_x <= n_fx - r_prev_x;
            r_change_y <= n_fy - r_prev_y;
            r_span     <= i_frm.span;
            r_status   <= i_frm.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_flow_x      = r_flow_x;
    assign o_flow_y      = r_flow_y;
    assign o_change_x    = r_change_x;
    assign o_change_y    = r_change_y;
    assign o_time_span   = r_span;
    assign o_status_byte = r_status;

`ifndef NO_ASSERTIONS
    a_prev_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm_take |=> (r_prev_x == r_flow_x && r_prev_y == r_flow_y))
        else $error("Filter history does not match the emitted item.");

    a_change_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm_take |=> r_change_x == FLOW_W'(r_flow_x - $past(r_prev_x)))
        else $error("Change of X does not match the filter history.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            (r_out_valid && $stable(r_flow_x) && $stable(r_flow_y) && $stable(r_status)))
        else $error("Result item changed while it was waiting.");
`endif

endmodule

[hdl/optical_flow_frame_parser_filter.sv]
// Top level of the optical-flow frame parser with low-pass flow filter.
//
//   Channel  Handshake                   Payload
//   input    i_in_valid / o_in_ready     i_rx_byte
//   output   o_out_valid / i_out_ready   o_flow_x, o_flow_y, o_change_x, o_change_y,
//                                        o_time_span, o_status_byte
//
// One byte item is taken every cycle while the output side keeps up.
// A good tail byte yields a result item after passing the frame register of the
// parser and then the filter's result register.
// Reset clears the frame position and the filter history; no clearing pass.
// A stalled output holds the result register and then the frame register,
// after which the input stops only while the frame register stays full.
module optical_flow_frame_parser_filter #(
    parameter int FRAME_LEN = ofp_pkg::FRAME_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ofp_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_flow_x,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_flow_y,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_change_x,
    output logic signed [ofp_pkg::FLOW_W-1:0]  o_change_y,
    output logic [ofp_pkg::FLOW_W-1:0]         o_time_span,
    output logic [ofp_pkg::BYTE_W-1:0]         o_status_byte
);
    import ofp_pkg::*;

    logic   frm_valid;
    logic   frm_ready;
    t_frame frm;

    ofp_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_frm_valid (frm_valid),
        .i_frm_ready (frm_ready),
        .o_frm       (frm)
    );

    ofp_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frm_valid   (frm_valid),
        .o_frm_ready   (frm_ready),
        .i_frm         (frm),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_flow_x      (o_flow_x),
        .o_flow_y      (o_flow_y),
        .o_change_x    (o_change_x),
        .o_change_y    (o_change_y),
        .o_time_span   (o_time_span),
        .o_status_byte (o_status_byte)
    );

endmodule
